### rtl/core/tppz_pkg.sv
// ----------------------------------------------------------------------------
// tppz_pkg - shared types and constants of the 3p3z compensator
// Holds the operand widths of the shared multiplier, configuration register
// indexes, limit flag codes and the constants of the pulse scaling.
// ----------------------------------------------------------------------------
package tppz_pkg;

    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    localparam int ERR_W  = 17;
    localparam int Y_W    = 32;
    localparam int CEIL_W = 31;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FF_COEF_0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FF_COEF_1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FF_COEF_2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FF_COEF_3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_COEF_1    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_COEF_2    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_COEF_3    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_CEIL  = 3'd7;

    typedef enum logic [1:0] {
        LIMIT_NONE  = 2'd0,
        LIMIT_CEIL  = 2'd1,
        LIMIT_FLOOR = 2'd2
    } t_limit;

    localparam logic [15:0] MIN_PULSE = 16'd100;
    localparam logic [15:0] MAX_PULSE = 16'd65535;

    // Division by three is a multiplication by ceil(2^22 / 3); it is exact for
    // quotients below 2^21, far beyond the saturation point below.
    localparam int          DIV_SHIFT = 22;
    localparam logic [31:0] DIV_RECIP = 32'd1398102;
    localparam int          Q_W       = 18;
    localparam logic [63:0] SAT_Q     = 64'd196608;

    localparam logic signed [31:0] FF0_RST  = -32'sd111405;
    localparam logic signed [31:0] FF1_RST  = 32'sd100518;
    localparam logic signed [31:0] FF2_RST  = 32'sd111379;
    localparam logic signed [31:0] FF3_RST  = -32'sd100544;
    localparam logic signed [31:0] FB1_RST  = 32'sd298772521;
    localparam logic signed [31:0] FB2_RST  = -32'sd10623258;
    localparam logic signed [31:0] FB3_RST  = -32'sd19713807;
    localparam logic [CEIL_W-1:0]  CEIL_RST = 31'd805306368;

endpackage

### rtl/core/tppz_mul.sv
// ----------------------------------------------------------------------------
// tppz_mul - shared signed multiplier
// One registered 32 by 32 signed multiplication; the product holds until the
// next enabled cycle.
// ----------------------------------------------------------------------------
module tppz_mul (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [tppz_pkg::MUL_W-1:0]   i_a,
    input  logic signed [tppz_pkg::MUL_W-1:0]   i_b,
    output logic signed [tppz_pkg::PROD_W-1:0]  o_p
);
    import tppz_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

### rtl/core/three_pole_three_zero_compensator_top.sv
// ----------------------------------------------------------------------------
// three_pole_three_zero_compensator_top - 3-pole 3-zero voltage loop filter
// Forms the error of each sample, runs the type 3 IIR in Q fixed point on one
// shared multiplier, clamps the result and scales it into a pulse width.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                         Contents
//  s         in         i_s_tvalid/o_s_tready/i_s_tdata measured, reference
//  m         out        o_m_tvalid/i_m_tready/o_m_tdata pulse_width, half_pulse,
//                                                       limit_hit
//  cfg       in         i_cfg_we/i_cfg_addr/i_cfg_wdata coefficient and ceiling
//
// An item passes from its input transaction to the output register through
// the seven products, each a multiply and an accumulate state on the shared
// multiplier and accumulator, then clamp, scale multiply, divide-by-three
// multiply and pulse limiting. The block takes one item at a time, and the next
// input transaction can follow in the cycle after the result is loaded.
// A result waiting on the output side does not hold off the next input
// transaction; only a second finished result waits for the output register.
// Reset (synchronous, active low) restores the default coefficients and ceiling
// and clears the error and output histories.
// ----------------------------------------------------------------------------
module three_pole_three_zero_compensator_top #(
    parameter int PWM_PERIOD_COUNTS = 27472,
    parameter int COEF_FRAC_BITS    = 28
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream, tdata from bit 0: measured[15:0], reference[31:16].
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [31:0]                        i_s_tdata,
    // Output stream, tdata from bit 0: pulse_width[15:0], half_pulse[30:16],
    // limit_hit[32:31], zero fill [39:33].
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [39:0]                        o_m_tdata,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [tppz_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [31:0]                        i_cfg_wdata
);
    import tppz_pkg::*;

    // 0.3 and 0.05 in the coefficient format, rounded to nearest.
    localparam logic signed [63:0] TENTHS3 =
        64'((64'sd3 <<< COEF_FRAC_BITS) + 64'sd5) / 64'sd10;
    localparam logic signed [63:0] HUNDREDTHS5 =
        64'((64'sd1 <<< COEF_FRAC_BITS) + 64'sd10) / 64'sd20;
    localparam logic signed [MUL_W-1:0] PERIOD_OP = MUL_W'(PWM_PERIOD_COUNTS);
    localparam logic [2:0] LAST_TERM = 3'd6;
    localparam logic [2:0] FIRST_FB  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC_MUL,
        S_MAC_ACC,
        S_CLAMP,
        S_SCALE,
        S_QUOT,
        S_PULSE
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic signed [31:0]       r_ff_coef [4];
    logic signed [31:0]       r_fb_coef [3];
    logic [CEIL_W-1:0]        r_ceil;

    // Filter state.
    logic signed [ERR_W-1:0]  r_err;
    logic signed [ERR_W-1:0]  r_err_hist [3];
    logic signed [Y_W-1:0]    r_y_hist [3];

    // Datapath.
    logic [2:0]               r_k;
    logic signed [63:0]       r_acc;
    logic                     r_ypos;
    logic                     r_sat;
    t_limit                   r_limit;

    // Output register.
    logic                     r_m_valid;
    logic [15:0]              r_pulse;
    logic [14:0]              r_half;
    t_limit                   r_m_limit;

    logic                     w_mul_en;
    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [63:0]       w_term;
    logic signed [63:0]       w_ceil;
    logic signed [Y_W-1:0]    w_y;
    t_limit                   w_limit;
    logic signed [63:0]       w_q;
    logic [15:0]              w_quot;
    logic [15:0]              w_pulse;
    logic                     w_out_free;

    tppz_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_out_free = !r_m_valid || i_m_tready;

    // Quotient of the scaled pulse by 2^F, the input of the divide by three.
    assign w_q = w_prod >>> COEF_FRAC_BITS;

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_en = 1'b0;
        w_mul_a  = '0;
        w_mul_b  = '0;
        unique case (r_state)
            S_MAC_MUL: begin
                w_mul_en = 1'b1;
                case (r_k)
                    3'd0: begin
                        w_mul_a = MUL_W'(r_err);
                        w_mul_b = r_ff_coef[0];
                    end
                    3'd1: begin
                        w_mul_a = MUL_W'(r_err_hist[0]);
                        w_mul_b = r_ff_coef[1];
                    end
                    3'd2: begin
                        w_mul_a = MUL_W'(r_err_hist[1]);
                        w_mul_b = r_ff_coef[2];
                    end
                    3'd3: begin
                        w_mul_a = MUL_W'(r_err_hist[2]);
                        w_mul_b = r_ff_coef[3];
                    end
                    3'd4: begin
                        w_mul_a = r_y_hist[0];
                        w_mul_b = r_fb_coef[0];
                    end
                    3'd5: begin
                        w_mul_a = r_y_hist[1];
                        w_mul_b = r_fb_coef[1];
                    end
                    3'd6: begin
                        w_mul_a = r_y_hist[2];
                        w_mul_b = r_fb_coef[2];
                    end
                    default: begin
                        w_mul_a = '0;
                        w_mul_b = '0;
                    end
                endcase
            end
            S_SCALE: begin
                // The newest history entry is the clamped output just formed.
                w_mul_en = 1'b1;
                w_mul_a  = r_y_hist[0];
                w_mul_b  = PERIOD_OP;
            end
            S_QUOT: begin
                w_mul_en = 1'b1;
                w_mul_a  = $signed({{(MUL_W-Q_W){1'b0}}, w_q[Q_W-1:0]});
                w_mul_b  = $signed(DIV_RECIP);
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    // Feedback products carry twice the fraction bits and are floored back.
    assign w_term = (r_k >= FIRST_FB) ? (w_prod >>> COEF_FRAC_BITS) : w_prod;

    // Clamp: the ceiling wins over the floor, and its value is kept even if it
    // lies below the floor.
    assign w_ceil = $signed({{(64-CEIL_W){1'b0}}, r_ceil});
    always_comb begin
        priority if (r_acc >= w_ceil) begin
            w_y     = $signed({1'b0, r_ceil}) - Y_W'(TENTHS3);
            w_limit = LIMIT_CEIL;
        end else if (r_acc <= HUNDREDTHS5) begin
            w_y     = Y_W'(HUNDREDTHS5);
            w_limit = LIMIT_FLOOR;
        end else begin
            w_y     = r_acc[Y_W-1:0];
            w_limit = LIMIT_NONE;
        end
    end

    // Pulse limiting after the divide by three.
    assign w_quot = w_prod[DIV_SHIFT +: 16];
    always_comb begin
        priority if (!r_ypos) begin
            w_pulse = MIN_PULSE;
        end else if (r_sat) begin
            w_pulse = MAX_PULSE;
        end else if (w_quot <= MIN_PULSE) begin
            w_pulse = MIN_PULSE;
        end else begin
            w_pulse = w_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_k           <= '0;
            r_m_valid     <= 1'b0;
            r_ff_coef[0]  <= FF0_RST;
            r_ff_coef[1]  <= FF1_RST;
            r_ff_coef[2]  <= FF2_RST;
            r_ff_coef[3]  <= FF3_RST;
            r_fb_coef[0]  <= FB1_RST;
            r_fb_coef[1]  <= FB2_RST;
            r_fb_coef[2]  <= FB3_RST;
            r_ceil        <= CEIL_RST;
            for (int i = 0; i < 3; i++) begin
                r_err_hist[i] <= '0;
                r_y_hist[i]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_FF_COEF_0:   r_ff_coef[0] <= $signed(i_cfg_wdata);
                    CFG_FF_COEF_1:   r_ff_coef[1] <= $signed(i_cfg_wdata);
                    CFG_FF_COEF_2:   r_ff_coef[2] <= $signed(i_cfg_wdata);
                    CFG_FF_COEF_3:   r_ff_coef[3] <= $signed(i_cfg_wdata);
                    CFG_FB_COEF_1:   r_fb_coef[0] <= $signed(i_cfg_wdata);
                    CFG_FB_COEF_2:   r_fb_coef[1] <= $signed(i_cfg_wdata);
                    CFG_FB_COEF_3:   r_fb_coef[2] <= $signed(i_cfg_wdata);
                    CFG_OUTPUT_CEIL: r_ceil       <= i_cfg_wdata[CEIL_W-1:0];
                endcase
            end

            // A new result is loaded only when the register is free, so the
            // load decides the flag whenever it coincides with a transaction.
            if (r_state == S_PULSE && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_err   <= $signed({1'b0, i_s_tdata[15:0]})
                                 - $signed({1'b0, i_s_tdata[31:16]});
                        r_acc   <= '0;
                        r_k     <= '0;
                        r_state <= S_MAC_MUL;
                    end
                end
                S_MAC_MUL: begin
                    r_state <= S_MAC_ACC;
                end
                S_MAC_ACC: begin
                    r_acc <= r_acc + w_term;
                    if (r_k == LAST_TERM) begin
                        r_state <= S_CLAMP;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_MAC_MUL;
                    end
                end
                S_CLAMP: begin
                    r_err_hist[2] <= r_err_hist[1];
                    r_err_hist[1] <= r_err_hist[0];
                    r_err_hist[0] <= r_err;
                    r_y_hist[2]   <= r_y_hist[1];
                    r_y_hist[1]   <= r_y_hist[0];
                    r_y_hist[0]   <= w_y;
                    r_ypos        <= (w_y > 0);
                    r_limit       <= w_limit;
                    r_state       <= S_SCALE;
                end
                S_SCALE: begin
                    r_state <= S_QUOT;
                end
                S_QUOT: begin
                    r_sat   <= ($unsigned(w_q) >= SAT_Q);
                    r_state <= S_PULSE;
                end
                S_PULSE: begin
                    if (w_out_free) begin
                        r_pulse   <= w_pulse;
                        r_half    <= w_pulse[15:1];
                        r_m_limit <= r_limit;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {7'd0, r_m_limit, r_half, r_pulse};

`ifndef SYNTHESIS
    // An accepted sample keeps the input side closed on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted again straight after a transaction");

    // A delivered pulse never falls below the minimum pulse width.
    a_min_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_pulse >= MIN_PULSE))
        else $error("pulse width below minimum");

    // A new result is loaded only when the previous one has gone.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(r_pulse)))
        else $error("pending result overwritten");

    // The term counter stays within the seven filter products.
    a_term_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC_ACC) |-> (r_k <= LAST_TERM))
        else $error("filter term counter out of range");

    // A clamp at the ceiling always enters the history as ceiling minus 0.3.
    a_ceil_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLAMP && w_limit == LIMIT_CEIL) |=>
        (r_y_hist[0] == $signed({1'b0, r_ceil}) - Y_W'(TENTHS3)))
        else $error("ceiling clamp value wrong");
`endif

endmodule
